// ----- hw/rtl/ccp_pkg.sv -----
// shared types, constants and helper functions for the comment counting parser
package ccp_pkg;

    localparam int COUNT_W = 32;
    localparam int OUT_W   = 32;
    localparam int CHAR_W  = 8;
    localparam int PREV_W  = CHAR_W + 1;

    localparam int DATA_BITS = 4 * OUT_W + 2;
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [OUT_W-1:0]   out_count_t;
    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [PREV_W-1:0]  prev_t;

    typedef enum logic [2:0] {
        MODE_OUT   = 3'd0,
        MODE_PAREN = 3'd1,
        MODE_BRACE = 3'd2,
        MODE_LINE  = 3'd3,
        MODE_QUOTE = 3'd4
    } mode_t;

    localparam prev_t PREV_NONE = prev_t'(1) << CHAR_W;

    localparam char_t CH_LPAREN  = 8'h28;
    localparam char_t CH_STAR    = 8'h2A;
    localparam char_t CH_RPAREN  = 8'h29;
    localparam char_t CH_LBRACE  = 8'h7B;
    localparam char_t CH_RBRACE  = 8'h7D;
    localparam char_t CH_SLASH   = 8'h2F;
    localparam char_t CH_NEWLINE = 8'h0A;
    localparam char_t CH_QUOTE   = 8'h27;

    function automatic count_t sat_inc(input count_t v);
        return (&v) ? v : v + count_t'(1);
    endfunction

    // clamp a counter to the 32-bit field
    function automatic out_count_t clamp_out(input count_t v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'(out_count_t'('1))) ? out_count_t'('1) : w[OUT_W-1:0];
    endfunction

    function automatic prev_t char_ext(input char_t c);
        return prev_t'(c);
    endfunction

endpackage

// ----- hw/rtl/comment_counting_parser.sv -----
// comment counting parser: span recognizer with saturating counters and stream handshake
//
// Input channel s_axis: one source character per request in s_axis_tdata[7:0];
// s_axis_tlast high marks end of text (the character is then ignored).
// Output channel m_axis: one result per accepted request, showing the counts
// after that character: closed paren-star comments, brace comments, newline
// ended line comments, quote literals, plus stream_ended and ended_open.
// m_axis_tvalid rises in the cycle after input accept. Throughput is one
// character per cycle while results are taken: the parser state is updated
// in a single pass of logic from the accepted character and the stored mode
// and previous character; those state registers also form the result register.
// When the receiver stalls, the held result stays on m_axis and s_axis_tready
// drops until it is taken; a new request is taken in the same cycle as the
// result is taken.
// After the end of text marker the block ignores characters but still answers
// each request with the final counts.
// Reset (aresetn low, synchronous) clears the counters, the flags, the mode
// and the output valid; the block is ready in the first cycle after reset.
module comment_counting_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // char_code
    input  logic                        s_axis_tlast,  // end_of_text
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // paren_star_count, brace_count, line_comment_count, quote_literal_count,
    // stream_ended, ended_open, zero fill
    output logic [ccp_pkg::TDATA_W-1:0] m_axis_tdata
);
    import ccp_pkg::*;

    mode_t  mode_reg, mode_next;
    prev_t  prev_reg, prev_next;
    count_t paren_reg, paren_next;
    count_t brace_reg, brace_next;
    count_t line_reg, line_next;
    count_t quote_reg, quote_next;
    logic   done_reg, done_next;
    logic   open_reg, open_next;
    logic   valid_reg, valid_next;

    logic  in_fire;
    char_t c;

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign c             = s_axis_tdata;

    always_comb begin
        mode_next  = mode_reg;
        prev_next  = prev_reg;
        paren_next = paren_reg;
        brace_next = brace_reg;
        line_next  = line_reg;
        quote_next = quote_reg;
        done_next  = done_reg;
        open_next  = open_reg;
        if (in_fire && !done_reg) begin
            if (s_axis_tlast) begin
                open_next = (mode_reg != MODE_OUT);
                done_next = 1'b1;
                prev_next = PREV_NONE;
            end else begin
                prev_next = char_ext(c);
                unique case (mode_reg)
                    MODE_PAREN: begin
                        if (prev_reg == char_ext(CH_STAR) && c == CH_RPAREN) begin
                            paren_next = sat_inc(paren_reg);
                            mode_next  = MODE_OUT;
                        end
                    end
                    MODE_BRACE: begin
                        if (c == CH_RBRACE) begin
                            brace_next = sat_inc(brace_reg);
                            mode_next  = MODE_OUT;
                        end
                    end
                    MODE_LINE: begin
                        if (c == CH_NEWLINE) begin
                            line_next = sat_inc(line_reg);
                            mode_next = MODE_OUT;
                        end
                    end
                    MODE_QUOTE: begin
                        if (c == CH_QUOTE) begin
                            quote_next = sat_inc(quote_reg);
                            mode_next  = MODE_OUT;
                        end
                    end
                    default: begin
                        // opener characters never count toward a closer
                        mode_next = MODE_OUT;
                        priority if (prev_reg == char_ext(CH_LPAREN) && c == CH_STAR) begin
                            mode_next = MODE_PAREN;
                            prev_next = PREV_NONE;
                        end else if (c == CH_LBRACE) begin
                            mode_next = MODE_BRACE;
                            prev_next = PREV_NONE;
                        end else if (prev_reg == char_ext(CH_SLASH) && c == CH_SLASH) begin
                            mode_next = MODE_LINE;
                            prev_next = PREV_NONE;
                        end else if (c == CH_QUOTE) begin
                            mode_next = MODE_QUOTE;
                            prev_next = PREV_NONE;
                        end else begin
                            mode_next = MODE_OUT;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_fire) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_OUT;
            prev_reg  <= PREV_NONE;
            paren_reg <= '0;
            brace_reg <= '0;
            line_reg  <= '0;
            quote_reg <= '0;
            done_reg  <= 1'b0;
            open_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            paren_reg <= paren_next;
            brace_reg <= brace_next;
            line_reg  <= line_next;
            quote_reg <= quote_next;
            done_reg  <= done_next;
            open_reg  <= open_next;
            valid_reg <= valid_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {(TDATA_W - DATA_BITS)'(0), open_reg, done_reg,
                            clamp_out(quote_reg), clamp_out(line_reg),
                            clamp_out(brace_reg), clamp_out(paren_reg)};

endmodule

// ----- hw/rtl/ccp_checker.sv -----
// port level checks for the comment counting parser, bound to the top level
module ccp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [ccp_pkg::TDATA_W-1:0] m_axis_tdata
);
    import ccp_pkg::*;

    localparam int ENDED_BIT = 4 * OUT_W;
    localparam int OPEN_BIT  = 4 * OUT_W + 1;

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // end of text is sticky
    a_ended_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tdata[ENDED_BIT] |=> m_axis_tdata[ENDED_BIT])
        else $error("stream_ended dropped");

    a_open_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tdata[OPEN_BIT] |-> m_axis_tdata[ENDED_BIT])
        else $error("ended_open without stream_ended");

    // results move only after an accepted request
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(in_fire) |-> $stable(m_axis_tdata))
        else $error("result changed without a request");

    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> m_axis_tdata[OUT_W-1:0] >= $past(m_axis_tdata[OUT_W-1:0]))
        else $error("paren-star count decreased");

endmodule

bind comment_counting_parser ccp_checker u_ccp_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// self-checking stream testbench for the comment counting parser
module testbench;
    import ccp_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int REPORT_LINES  = 40;
    localparam int LONG_HOLD     = 300;

    typedef struct packed {
        out_count_t paren;
        out_count_t brace;
        out_count_t line;
        out_count_t quote;
        logic       ended;
        logic       open_span;
    } count_snapshot_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // char_code
    logic                 s_axis_tlast;   // end_of_text
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // paren_star_count, brace_count, line_comment_count, quote_literal_count,
    // stream_ended, ended_open, zero fill
    logic [TDATA_W-1:0]   m_axis_tdata;

    // parser state as the testbench tracks it
    mode_t  parser_mode   = MODE_OUT;
    prev_t  parser_prev   = PREV_NONE;
    count_t paren_total   = '0;
    count_t brace_total   = '0;
    count_t line_total    = '0;
    count_t quote_total   = '0;
    logic   parser_done   = 1'b0;
    logic   parser_open   = 1'b0;

    count_snapshot_t pending_counts[$];

    int chars_sent        = 0;
    int results_seen      = 0;
    int mismatch_count    = 0;
    int stalled_cycles    = 0;
    int long_hold_cycles  = 0;
    bit source_gaps_on    = 1'b0;
    bit sink_gaps_on      = 1'b0;

    comment_counting_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic count_t bump(input count_t v);
        return (v == {COUNT_W{1'b1}}) ? v : v + count_t'(1);
    endfunction

    // counters wider than the output field show as all ones once past it
    function automatic out_count_t shown(input count_t v);
        if (COUNT_W > OUT_W && (v >> OUT_W) != 0) return '1;
        return v[OUT_W-1:0];
    endfunction

    task automatic advance_parser(input char_t c, input logic eot);
        prev_t next_prev;
        count_snapshot_t snap;
        next_prev = prev_t'(c);
        if (!parser_done) begin
            if (eot) begin
                parser_open = (parser_mode != MODE_OUT);
                parser_done = 1'b1;
                parser_prev = PREV_NONE;
            end else begin
                case (parser_mode)
                    MODE_PAREN: begin
                        if (parser_prev == prev_t'(CH_STAR) && c == CH_RPAREN) begin
                            paren_total = bump(paren_total);
                            parser_mode = MODE_OUT;
                        end
                    end
                    MODE_BRACE: begin
                        if (c == CH_RBRACE) begin
                            brace_total = bump(brace_total);
                            parser_mode = MODE_OUT;
                        end
                    end
                    MODE_LINE: begin
                        if (c == CH_NEWLINE) begin
                            line_total = bump(line_total);
                            parser_mode = MODE_OUT;
                        end
                    end
                    MODE_QUOTE: begin
                        if (c == CH_QUOTE) begin
                            quote_total = bump(quote_total);
                            parser_mode = MODE_OUT;
                        end
                    end
                    default: begin
                        parser_mode = MODE_OUT;
                        if (parser_prev == prev_t'(CH_LPAREN) && c == CH_STAR) begin
                            parser_mode = MODE_PAREN;
                        end else if (c == CH_LBRACE) begin
                            parser_mode = MODE_BRACE;
                        end else if (parser_prev == prev_t'(CH_SLASH) && c == CH_SLASH) begin
                            parser_mode = MODE_LINE;
                        end else if (c == CH_QUOTE) begin
                            parser_mode = MODE_QUOTE;
                        end
                        // opener characters never count toward a closer
                        if (parser_mode != MODE_OUT) next_prev = PREV_NONE;
                    end
                endcase
                parser_prev = next_prev;
            end
        end
        snap.paren     = shown(paren_total);
        snap.brace     = shown(brace_total);
        snap.line      = shown(line_total);
        snap.quote     = shown(quote_total);
        snap.ended     = parser_done;
        snap.open_span = parser_open;
        pending_counts.push_back(snap);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // one request; valid stays up between back-to-back characters
    task automatic send_char(input char_t c, input logic eot);
        if (source_gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do @(posedge aclk); while (!s_axis_tready);
        chars_sent++;
        advance_parser(c, eot);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_char(char_t'(s[i]), 1'b0);
    endtask

    function automatic char_t pick_char();
        case ($urandom_range(0, 15))
            0:       return CH_LPAREN;
            1:       return CH_STAR;
            2:       return CH_RPAREN;
            3:       return CH_LBRACE;
            4:       return CH_RBRACE;
            5:       return CH_SLASH;
            6:       return CH_NEWLINE;
            7:       return CH_QUOTE;
            default: return char_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_body(input int len);
        repeat (len) send_char(pick_char(), 1'b0);
    endtask

    // well formed spans with random bodies, some left open, lone half openers, noise
    task automatic emit_fragment();
        int  kind;
        int  len;
        bit  broken;
        kind   = $urandom_range(0, 7);
        len    = $urandom_range(0, 8);
        broken = ($urandom_range(0, 7) == 0);
        case (kind)
            0: begin
                send_text("(*");
                send_body(len);
                if (!broken) send_text("*)");
            end
            1: begin
                send_char(CH_LBRACE, 1'b0);
                send_body(len);
                if (!broken) send_char(CH_RBRACE, 1'b0);
            end
            2: begin
                send_text("//");
                send_body(len);
                if (!broken) send_char(CH_NEWLINE, 1'b0);
            end
            3: begin
                send_char(CH_QUOTE, 1'b0);
                send_body(len);
                if (!broken) send_char(CH_QUOTE, 1'b0);
            end
            4: begin
                send_char($urandom_range(0, 1) ? CH_LPAREN : CH_SLASH, 1'b0);
                send_body(len);
            end
            default: begin
                repeat (len + 1) send_char(char_t'($urandom_range(0, 255)), 1'b0);
            end
        endcase
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_counts.size() != 0);
    endtask

    task automatic test_directed_spans();
        source_gaps_on = 1'b0;
        sink_gaps_on   = 1'b0;
        send_text("(*)*)");     // star of the opener does not close
        send_text("{}");
        send_text("//x\n");
        send_text("''");        // empty literal
        send_text("/a/");       // split slashes open nothing
        send_text("{(*}");      // nested opener inside a brace comment
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        pause_until_drained();
    endtask

    task automatic test_random_text();
        int stop_at;
        source_gaps_on = 1'b1;
        sink_gaps_on   = 1'b1;
        stop_at = chars_sent + 500;
        while (chars_sent < stop_at) emit_fragment();
        sink_gaps_on = 1'b0;
        stop_at += 500;
        while (chars_sent < stop_at) emit_fragment();
        source_gaps_on = 1'b0;
        sink_gaps_on   = 1'b1;
        stop_at += 500;
        while (chars_sent < stop_at) emit_fragment();
        pause_until_drained();
    endtask

    // receiver holds off for a long stretch while characters keep coming
    task automatic test_backpressure();
        source_gaps_on   = 1'b0;
        sink_gaps_on     = 1'b0;
        long_hold_cycles = LONG_HOLD;
        repeat (40) send_char(pick_char(), 1'b0);
        pause_until_drained();
    endtask

    task automatic test_quiet_tail();
        int stop_at;
        source_gaps_on = 1'b0;
        sink_gaps_on   = 1'b0;
        stop_at = chars_sent + 250;
        while (chars_sent < stop_at) emit_fragment();
    endtask

    // end of text lands outside, inside a span or right after a lone half opener
    task automatic test_end_of_text();
        string endings[6];
        endings = '{"", "(*ab", "(", "/", "'x", "{z"};
        send_text(endings[$urandom_range(0, 5)]);
        send_char(char_t'($urandom_range(0, 255)), 1'b1);
        repeat (6) send_char(char_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin : sink
        m_axis_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (long_hold_cycles) @(posedge aclk);
                long_hold_cycles = 0;
            end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        count_snapshot_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_counts.size() == 0) begin
                report_mismatch("result with nothing expected", m_axis_tdata[63:0], '0);
            end else begin
                want = pending_counts.pop_front();
                if (m_axis_tdata[OUT_W-1:0] !== want.paren)
                    report_mismatch("paren_star_count", m_axis_tdata[OUT_W-1:0], want.paren);
                if (m_axis_tdata[2*OUT_W-1:OUT_W] !== want.brace)
                    report_mismatch("brace_count", m_axis_tdata[2*OUT_W-1:OUT_W], want.brace);
                if (m_axis_tdata[3*OUT_W-1:2*OUT_W] !== want.line)
                    report_mismatch("line_comment_count", m_axis_tdata[3*OUT_W-1:2*OUT_W],
                                    want.line);
                if (m_axis_tdata[4*OUT_W-1:3*OUT_W] !== want.quote)
                    report_mismatch("quote_literal_count", m_axis_tdata[4*OUT_W-1:3*OUT_W],
                                    want.quote);
                if (m_axis_tdata[4*OUT_W] !== want.ended)
                    report_mismatch("stream_ended", m_axis_tdata[4*OUT_W], want.ended);
                if (m_axis_tdata[4*OUT_W+1] !== want.open_span)
                    report_mismatch("ended_open", m_axis_tdata[4*OUT_W+1], want.open_span);
                if (m_axis_tdata[TDATA_W-1:DATA_BITS] !== '0)
                    report_mismatch("zero fill", m_axis_tdata[TDATA_W-1:DATA_BITS], '0);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin : run
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_spans();
        test_random_text();
        test_backpressure();
        test_quiet_tail();
        test_end_of_text();

        s_axis_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("checked %0d results for %0d characters; closed paren-star %0d, brace %0d,"
                 , results_seen, chars_sent, paren_total, brace_total);
        $display("line %0d, quote %0d; text ended %s a span, %0d mismatches",
                 line_total, quote_total, parser_open ? "inside" : "outside",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
